>>> hw/rtl/asd_pkg.sv
`timescale 1ns / 1ps

package asd_pkg;

    localparam int MAGIC_LENGTH_DEFAULT = 7;
    localparam int POS_W = 3;
    localparam int MAGIC_MAX = 8;

    // Magic bytes in stream order, first byte in the low byte.
    localparam logic [8*MAGIC_MAX-1:0] MAGIC_WORD = 64'h00_01_00_35_36_52_41_4E;

    localparam logic [7:0] SLASH_BYTE = 8'h2F;
    localparam logic [7:0] BACKSLASH_BYTE = 8'h5C;

    localparam logic [POS_W-1:0] HDR_LAST_POS = 3'd5;

    typedef enum logic [1:0] {
        PH_MAGIC,
        PH_HEADER,
        PH_NAME,
        PH_PAYLOAD
    } phase_t;

    typedef enum logic [2:0] {
        KIND_NAME    = 3'd0,
        KIND_PAYLOAD = 3'd1,
        KIND_HEADER  = 3'd2,
        KIND_DONE    = 3'd3,
        KIND_ERROR   = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK            = 3'd0,
        ST_TOO_SHORT     = 3'd1,
        ST_BAD_MAGIC     = 3'd2,
        ST_TRUNC_HEADER  = 3'd3,
        ST_ZERO_NAME     = 3'd4,
        ST_TRUNC_NAME    = 3'd5,
        ST_SUSPECT_NAME  = 3'd6,
        ST_TRUNC_PAYLOAD = 3'd7
    } status_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       stream_end;
    } in_beat_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  out_byte;
        logic [15:0] name_length;
        logic [31:0] member_size;
        logic        member_last;
        status_t     status;
    } out_beat_t;

    function automatic logic [7:0] magic_byte(input logic [POS_W-1:0] idx);
        logic [7:0] b;
        b = MAGIC_WORD[8*idx +: 8];
        return b;
    endfunction

endpackage

>>> hw/rtl/archive_stream_deframer.sv
`timescale 1ns / 1ps

// Channel   Signals                          Direction  Content
// arc       arc_valid arc_ready arc_beat     in         stream byte or end marker
// res       res_valid res_ready res_beat     out        header, byte, done or error
//
// One beat is accepted every cycle while results are taken; each beat passes an
// input register and then a result register, where its result, if any, is written.
// The parse step between the two registers is combinational.
// A stall on res_ready holds the result register, then the input register,
// and only then drops arc_ready.
// Reset clears all parse state; after an error or end of archive the block
// keeps taking beats but gives no further results until reset.

module archive_stream_deframer #(
    parameter int MAGIC_LENGTH = asd_pkg::MAGIC_LENGTH_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               arc_valid,
    output logic               arc_ready,
    input  asd_pkg::in_beat_t  arc_beat,
    output logic               res_valid,
    input  logic               res_ready,
    output asd_pkg::out_beat_t res_beat
);

    localparam logic [asd_pkg::POS_W-1:0] MAGIC_LAST_POS =
        asd_pkg::POS_W'(MAGIC_LENGTH - 1);

    logic                      in_valid_reg;
    asd_pkg::in_beat_t         in_beat_reg;
    logic                      res_valid_reg;
    asd_pkg::out_beat_t        res_beat_reg;
    asd_pkg::out_beat_t        res_next;
    logic                      has_res;
    logic                      adv;

    asd_pkg::phase_t           phase_reg;
    asd_pkg::phase_t           phase_next;
    logic [asd_pkg::POS_W-1:0] pos_reg;
    logic [asd_pkg::POS_W-1:0] pos_next;
    logic                      mism_reg;
    logic                      mism_next;
    logic [15:0]               nl_reg;
    logic [15:0]               nl_next;
    logic [31:0]               ms_reg;
    logic [31:0]               ms_next;
    logic [31:0]               bl_reg;
    logic [31:0]               bl_next;
    logic                      zs_reg;
    logic                      zs_next;
    logic                      halt_reg;
    logic                      halt_next;

    logic [7:0]                b;
    logic                      fin;
    logic                      mism_cur;
    logic [15:0]               nl_cur;
    logic [31:0]               ms_cur;
    logic [31:0]               bl_dec;
    logic                      name_bad;

    assign adv       = in_valid_reg && (!res_valid_reg || res_ready);
    assign arc_ready = !in_valid_reg || adv;
    assign res_valid = res_valid_reg;
    assign res_beat  = res_beat_reg;

    assign b        = in_beat_reg.in_byte;
    assign fin      = in_beat_reg.stream_end;
    assign mism_cur = mism_reg || (b != asd_pkg::magic_byte(pos_reg));
    assign bl_dec   = bl_reg - 32'd1;
    assign name_bad = !zs_reg && (b == asd_pkg::SLASH_BYTE || b == asd_pkg::BACKSLASH_BYTE);

    always_comb
    begin
        nl_cur = nl_reg;
        ms_cur = ms_reg;
        case (pos_reg)
            3'd0: nl_cur = {nl_reg[15:8], b};
            3'd1: nl_cur = {b, nl_reg[7:0]};
            3'd2: ms_cur = {ms_reg[31:8], b};
            3'd3: ms_cur = {ms_reg[31:16], b, ms_reg[7:0]};
            3'd4: ms_cur = {ms_reg[31:24], b, ms_reg[15:0]};
            3'd5: ms_cur = {b, ms_reg[23:0]};
            default: ;
        endcase
    end

    always_comb
    begin
        phase_next = phase_reg;
        if (!halt_reg && !fin)
        begin
            unique case (phase_reg)
                asd_pkg::PH_MAGIC:
                begin
                    if (pos_reg == MAGIC_LAST_POS && !mism_cur)
                        phase_next = asd_pkg::PH_HEADER;
                end
                asd_pkg::PH_HEADER:
                begin
                    if (pos_reg == asd_pkg::HDR_LAST_POS && nl_cur != 16'd0)
                        phase_next = asd_pkg::PH_NAME;
                end
                asd_pkg::PH_NAME:
                begin
                    if (!name_bad && bl_dec == 32'd0)
                        phase_next = (ms_reg == 32'd0) ? asd_pkg::PH_HEADER
                                                       : asd_pkg::PH_PAYLOAD;
                end
                asd_pkg::PH_PAYLOAD:
                begin
                    if (bl_dec == 32'd0)
                        phase_next = asd_pkg::PH_HEADER;
                end
                default: phase_next = phase_reg;
            endcase
        end
    end

    always_comb
    begin
        pos_next  = pos_reg;
        mism_next = mism_reg;
        nl_next   = nl_reg;
        ms_next   = ms_reg;
        bl_next   = bl_reg;
        zs_next   = zs_reg;
        halt_next = halt_reg;
        has_res   = 1'b0;
        res_next  = '0;
        if (!halt_reg)
        begin
            unique case (phase_reg)
                asd_pkg::PH_MAGIC:
                begin
                    if (fin)
                    begin
                        halt_next       = 1'b1;
                        has_res         = 1'b1;
                        res_next.kind   = asd_pkg::KIND_ERROR;
                        res_next.status = asd_pkg::ST_TOO_SHORT;
                    end
                    else
                    begin
                        mism_next = mism_cur;
                        if (pos_reg != MAGIC_LAST_POS)
                            pos_next = pos_reg + 3'd1;
                        else if (mism_cur)
                        begin
                            halt_next       = 1'b1;
                            has_res         = 1'b1;
                            res_next.kind   = asd_pkg::KIND_ERROR;
                            res_next.status = asd_pkg::ST_BAD_MAGIC;
                        end
                        else
                        begin
                            pos_next = '0;
                            nl_next  = '0;
                            ms_next  = '0;
                        end
                    end
                end
                asd_pkg::PH_HEADER:
                begin
                    if (fin)
                    begin
                        halt_next = 1'b1;
                        has_res   = 1'b1;
                        if (pos_reg == '0)
                            res_next.kind = asd_pkg::KIND_DONE;
                        else
                        begin
                            res_next.kind   = asd_pkg::KIND_ERROR;
                            res_next.status = asd_pkg::ST_TRUNC_HEADER;
                        end
                    end
                    else
                    begin
                        nl_next = nl_cur;
                        ms_next = ms_cur;
                        if (pos_reg != asd_pkg::HDR_LAST_POS)
                            pos_next = pos_reg + 3'd1;
                        else if (nl_cur == 16'd0)
                        begin
                            halt_next       = 1'b1;
                            has_res         = 1'b1;
                            res_next.kind   = asd_pkg::KIND_ERROR;
                            res_next.status = asd_pkg::ST_ZERO_NAME;
                        end
                        else
                        begin
                            pos_next             = '0;
                            bl_next              = {16'd0, nl_cur};
                            zs_next              = 1'b0;
                            has_res              = 1'b1;
                            res_next.kind        = asd_pkg::KIND_HEADER;
                            res_next.name_length = nl_cur;
                            res_next.member_size = ms_cur;
                        end
                    end
                end
                asd_pkg::PH_NAME:
                begin
                    has_res = 1'b1;
                    if (fin || name_bad)
                    begin
                        halt_next       = 1'b1;
                        res_next.kind   = asd_pkg::KIND_ERROR;
                        res_next.status = fin ? asd_pkg::ST_TRUNC_NAME
                                              : asd_pkg::ST_SUSPECT_NAME;
                    end
                    else
                    begin
                        zs_next           = zs_reg || (b == 8'd0);
                        bl_next           = bl_dec;
                        res_next.kind     = asd_pkg::KIND_NAME;
                        res_next.out_byte = b;
                        if (bl_dec == 32'd0)
                        begin
                            if (ms_reg == 32'd0)
                            begin
                                nl_next              = '0;
                                res_next.member_last = 1'b1;
                            end
                            else
                                bl_next = ms_reg;
                        end
                    end
                end
                asd_pkg::PH_PAYLOAD:
                begin
                    has_res = 1'b1;
                    if (fin)
                    begin
                        halt_next       = 1'b1;
                        res_next.kind   = asd_pkg::KIND_ERROR;
                        res_next.status = asd_pkg::ST_TRUNC_PAYLOAD;
                    end
                    else
                    begin
                        bl_next           = bl_dec;
                        res_next.kind     = asd_pkg::KIND_PAYLOAD;
                        res_next.out_byte = b;
                        if (bl_dec == 32'd0)
                        begin
                            pos_next             = '0;
                            nl_next              = '0;
                            ms_next              = '0;
                            res_next.member_last = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            phase_reg     <= asd_pkg::PH_MAGIC;
            pos_reg       <= '0;
            mism_reg      <= 1'b0;
            nl_reg        <= '0;
            ms_reg        <= '0;
            bl_reg        <= '0;
            zs_reg        <= 1'b0;
            halt_reg      <= 1'b0;
        end
        else
        begin
            if (arc_ready)
                in_valid_reg <= arc_valid;
            if (adv)
            begin
                res_valid_reg <= has_res;
                phase_reg     <= phase_next;
                pos_reg       <= pos_next;
                mism_reg      <= mism_next;
                nl_reg        <= nl_next;
                ms_reg        <= ms_next;
                bl_reg        <= bl_next;
                zs_reg        <= zs_next;
                halt_reg      <= halt_next;
            end
            else if (res_ready)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (arc_valid && arc_ready)
            in_beat_reg <= arc_beat;
        if (adv && has_res)
            res_beat_reg <= res_next;
    end

`ifndef SYNTHESIS
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halt_reg |=> halt_reg)
        else $error("halt flag cleared without reset");

    a_count_live: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == asd_pkg::PH_NAME || phase_reg == asd_pkg::PH_PAYLOAD) |->
        bl_reg != 32'd0)
        else $error("byte count is zero inside a name or payload");

    a_hdr_pos: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == asd_pkg::PH_HEADER |-> pos_reg <= asd_pkg::HDR_LAST_POS)
        else $error("header byte position out of range");

    a_hdr_name: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_beat_reg.kind == asd_pkg::KIND_HEADER) |->
        res_beat_reg.name_length != 16'd0)
        else $error("member header with empty name");

    a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_beat_reg.member_last) |->
        (res_beat_reg.kind == asd_pkg::KIND_NAME ||
         res_beat_reg.kind == asd_pkg::KIND_PAYLOAD))
        else $error("member end flag on a non-byte result");
`endif

endmodule

>>> dv/archive_stream_deframer_tb.sv
`timescale 1ns / 1ps

module archive_stream_deframer_tb;
    import asd_pkg::*;

    localparam int ITEM_TARGET = 400;
    localparam int CYCLE_LIMIT = 200000;
    localparam int REPORT_LIMIT = 10;

    class deframe_scoreboard;
        phase_t    phase = PH_MAGIC;
        bit [2:0]  pos = '0;
        bit        magic_bad = 1'b0;
        bit [15:0] name_count = '0;
        bit [31:0] payload_len = '0;
        bit [31:0] remaining = '0;
        bit        zero_seen = 1'b0;
        bit        halted = 1'b0;
        out_beat_t due_results[$];
        int        errors = 0;

        function out_beat_t halt_with(status_t st);
            out_beat_t r;
            r = '0;
            r.kind = KIND_ERROR;
            r.status = st;
            halted = 1'b1;
            return r;
        endfunction

        function string beat_text(out_beat_t v);
            return $sformatf("kind %0d byte %02h name_length %0d size %0d last %0d status %0d",
                             v.kind, v.out_byte, v.name_length, v.member_size,
                             v.member_last, v.status);
        endfunction

        function int due_count();
            return due_results.size();
        endfunction

        // Works out the result, if any, that one accepted input beat causes.
        function void parse_beat(in_beat_t b);
            out_beat_t r;
            bit emit;
            r = '0;
            emit = 1'b0;
            if (halted)
                return;
            case (phase)
                PH_MAGIC:
                begin
                    if (b.stream_end)
                    begin
                        r = halt_with(ST_TOO_SHORT);
                        emit = 1'b1;
                    end
                    else
                    begin
                        if (b.in_byte != MAGIC_WORD[8*pos +: 8])
                            magic_bad = 1'b1;
                        if (int'(pos) + 1 >= MAGIC_LENGTH_DEFAULT)
                        begin
                            if (magic_bad)
                            begin
                                r = halt_with(ST_BAD_MAGIC);
                                emit = 1'b1;
                            end
                            else
                            begin
                                phase = PH_HEADER;
                                pos = '0;
                                name_count = '0;
                                payload_len = '0;
                            end
                        end
                        else
                        begin
                            pos = pos + 3'd1;
                        end
                    end
                end
                PH_HEADER:
                begin
                    emit = 1'b1;
                    if (b.stream_end)
                    begin
                        if (pos == 3'd0)
                        begin
                            r.kind = KIND_DONE;
                            halted = 1'b1;
                        end
                        else
                        begin
                            r = halt_with(ST_TRUNC_HEADER);
                        end
                    end
                    else
                    begin
                        if (pos < 3'd2)
                            name_count = name_count | (16'(b.in_byte) << (8 * pos));
                        else
                            payload_len = payload_len | (32'(b.in_byte) << (8 * (pos - 3'd2)));
                        if (pos < HDR_LAST_POS)
                        begin
                            pos = pos + 3'd1;
                            emit = 1'b0;
                        end
                        else if (name_count == 16'd0)
                        begin
                            r = halt_with(ST_ZERO_NAME);
                        end
                        else
                        begin
                            phase = PH_NAME;
                            pos = '0;
                            remaining = 32'(name_count);
                            zero_seen = 1'b0;
                            r.kind = KIND_HEADER;
                            r.name_length = name_count;
                            r.member_size = payload_len;
                        end
                    end
                end
                PH_NAME:
                begin
                    emit = 1'b1;
                    if (b.stream_end)
                    begin
                        r = halt_with(ST_TRUNC_NAME);
                    end
                    else if (!zero_seen && (b.in_byte == SLASH_BYTE ||
                                            b.in_byte == BACKSLASH_BYTE))
                    begin
                        r = halt_with(ST_SUSPECT_NAME);
                    end
                    else
                    begin
                        if (b.in_byte == 8'd0)
                            zero_seen = 1'b1;
                        remaining = remaining - 32'd1;
                        r.kind = KIND_NAME;
                        r.out_byte = b.in_byte;
                        if (remaining == 32'd0)
                        begin
                            if (payload_len == 32'd0)
                            begin
                                phase = PH_HEADER;
                                name_count = '0;
                                r.member_last = 1'b1;
                            end
                            else
                            begin
                                phase = PH_PAYLOAD;
                                remaining = payload_len;
                            end
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    emit = 1'b1;
                    if (b.stream_end)
                    begin
                        r = halt_with(ST_TRUNC_PAYLOAD);
                    end
                    else
                    begin
                        remaining = remaining - 32'd1;
                        r.kind = KIND_PAYLOAD;
                        r.out_byte = b.in_byte;
                        if (remaining == 32'd0)
                        begin
                            phase = PH_HEADER;
                            pos = '0;
                            name_count = '0;
                            payload_len = '0;
                            r.member_last = 1'b1;
                        end
                    end
                end
                default:
                begin
                    emit = 1'b0;
                end
            endcase
            if (emit)
                due_results.push_back(r);
        endfunction

        function void compare_result(out_beat_t got);
            out_beat_t want;
            if (due_results.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("Unexpected result beat: %s", beat_text(got));
                return;
            end
            want = due_results.pop_front();
            if (got.kind !== want.kind || got.out_byte !== want.out_byte ||
                got.name_length !== want.name_length || got.member_size !== want.member_size ||
                got.member_last !== want.member_last || got.status !== want.status)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                begin
                    $display("Result mismatch at %0t", $realtime);
                    $display("  expected: %s", beat_text(want));
                    $display("  actual:   %s", beat_text(got));
                end
            end
        endfunction
    endclass

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      arc_valid = 1'b0;
    logic      arc_ready;
    in_beat_t  arc_beat = '0;
    logic      res_valid;
    logic      res_ready = 1'b0;
    out_beat_t res_beat;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int beats_sent = 0;
    int cycles = 0;

    deframe_scoreboard sb;

    archive_stream_deframer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .arc_valid (arc_valid),
        .arc_ready (arc_ready),
        .arc_beat  (arc_beat),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_beat  (res_beat)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        res_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (arc_valid && arc_ready)
                sb.parse_beat(arc_beat);
            if (res_valid && res_ready)
                sb.compare_result(res_beat);
        end
    end

    task automatic send_beat(input logic [7:0] value, input logic marker);
        in_beat_t b;
        if (beats_sent < ITEM_TARGET / 3)
        begin
            send_idle_pct = 18;
            recv_idle_pct = 57;
        end
        else if (beats_sent < 2 * ITEM_TARGET / 3)
        begin
            send_idle_pct = 57;
            recv_idle_pct = 18;
        end
        else
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            arc_valid <= 1'b0;
            @(posedge clk);
        end
        b.in_byte = value;
        b.stream_end = marker;
        arc_valid <= 1'b1;
        arc_beat <= b;
        @(posedge clk);
        while (!arc_ready)
            @(posedge clk);
        beats_sent++;
    endtask

    task automatic send_end();
        send_beat(8'($urandom), 1'b1);
    endtask

    task automatic drain_results();
        arc_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.due_count() != 0);
    endtask

    task automatic send_magic(input int count, input bit spoil);
        int bad_pos;
        logic [7:0] v;
        bad_pos = spoil ? $urandom_range(0, MAGIC_LENGTH_DEFAULT - 1) : -1;
        for (int i = 0; i < count; i++)
        begin
            v = MAGIC_WORD[8*i +: 8];
            if (i == bad_pos)
                v = v ^ 8'($urandom_range(1, 255));
            send_beat(v, 1'b0);
        end
    endtask

    task automatic send_header(input logic [15:0] nlen, input logic [31:0] plen);
        send_beat(nlen[7:0], 1'b0);
        send_beat(nlen[15:8], 1'b0);
        for (int i = 0; i < 4; i++)
            send_beat(plen[8*i +: 8], 1'b0);
    endtask

    // Name bytes avoid path separators until a zero byte has gone by.
    task automatic send_name(input int count);
        logic [7:0] v;
        bit zs;
        zs = 1'b0;
        for (int i = 0; i < count; i++)
        begin
            if (zs && $urandom_range(0, 3) == 0)
                v = $urandom_range(0, 1) ? SLASH_BYTE : BACKSLASH_BYTE;
            else if ($urandom_range(0, 9) == 0)
                v = 8'd0;
            else
            begin
                do
                    v = 8'($urandom);
                while (!zs && (v == SLASH_BYTE || v == BACKSLASH_BYTE));
            end
            if (v == 8'd0)
                zs = 1'b1;
            send_beat(v, 1'b0);
        end
    endtask

    task automatic send_payload(input int count);
        for (int i = 0; i < count; i++)
            send_beat(8'($urandom), 1'b0);
    endtask

    task automatic send_random_member();
        int nlen;
        int plen;
        case ($urandom_range(0, 29))
            0:       nlen = $urandom_range(256, 300);
            1, 2, 3: nlen = $urandom_range(9, 40);
            default: nlen = $urandom_range(1, 8);
        endcase
        case ($urandom_range(0, 9))
            0, 1:    plen = 0;
            2:       plen = $urandom_range(13, 60);
            default: plen = $urandom_range(1, 12);
        endcase
        send_header(16'(nlen), 32'(plen));
        send_name(nlen);
        send_payload(plen);
    endtask

    initial
    begin
        status_t ending;
        int pick;
        int nlen;
        int k;
        int tail;
        bit paused;
        logic [7:0] v;
        sb = new;
        paused = 1'b0;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            ending = ST_TOO_SHORT;
        else if (pick == 1)
            ending = ST_BAD_MAGIC;
        else
        begin
            case (pick % 6)
                0:       ending = ST_OK;
                1:       ending = ST_TRUNC_HEADER;
                2:       ending = ST_ZERO_NAME;
                3:       ending = ST_TRUNC_NAME;
                4:       ending = ST_SUSPECT_NAME;
                default: ending = ST_TRUNC_PAYLOAD;
            endcase
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        if (ending == ST_TOO_SHORT)
        begin
            send_magic($urandom_range(0, MAGIC_LENGTH_DEFAULT - 1), 1'b0);
            send_end();
        end
        else if (ending == ST_BAD_MAGIC)
        begin
            send_magic(MAGIC_LENGTH_DEFAULT, 1'b1);
        end
        else
        begin
            send_magic(MAGIC_LENGTH_DEFAULT, 1'b0);

            // Separators after a zero byte are allowed, then a name-only member.
            send_header(16'd4, 32'd2);
            send_beat(8'h61, 1'b0);
            send_beat(8'h00, 1'b0);
            send_beat(SLASH_BYTE, 1'b0);
            send_beat(BACKSLASH_BYTE, 1'b0);
            send_beat(8'h00, 1'b0);
            send_beat(8'hFF, 1'b0);
            send_header(16'd1, 32'd0);
            send_beat(8'hFF, 1'b0);

            while (beats_sent < ITEM_TARGET)
            begin
                send_random_member();
                if (!paused && beats_sent >= ITEM_TARGET / 2)
                begin
                    drain_results();
                    paused = 1'b1;
                end
            end

            case (ending)
                ST_TRUNC_HEADER:
                begin
                    send_payload($urandom_range(1, 5));
                    send_end();
                end
                ST_ZERO_NAME:
                begin
                    send_header(16'd0, 32'($urandom));
                end
                ST_TRUNC_NAME:
                begin
                    send_header(16'hFFFF, 32'($urandom));
                    send_name($urandom_range(0, 20));
                    send_end();
                end
                ST_SUSPECT_NAME:
                begin
                    nlen = $urandom_range(1, 10);
                    send_header(16'(nlen), 32'($urandom_range(0, 20)));
                    k = $urandom_range(0, nlen - 1);
                    for (int i = 0; i < k; i++)
                    begin
                        do
                            v = 8'($urandom);
                        while (v == 8'd0 || v == SLASH_BYTE || v == BACKSLASH_BYTE);
                        send_beat(v, 1'b0);
                    end
                    send_beat($urandom_range(0, 1) ? SLASH_BYTE : BACKSLASH_BYTE, 1'b0);
                end
                ST_TRUNC_PAYLOAD:
                begin
                    nlen = $urandom_range(1, 6);
                    send_header(16'(nlen), 32'hFFFF_FFFF);
                    send_name(nlen);
                    send_payload($urandom_range(0, 30));
                    send_end();
                end
                default:
                begin
                    send_end();
                end
            endcase
        end

        // Once halted, the block must stay silent whatever arrives.
        tail = 0;
        while (tail < 20 || beats_sent < ITEM_TARGET)
        begin
            send_beat(8'($urandom), 1'($urandom_range(0, 1)));
            tail++;
            if (!paused && beats_sent >= ITEM_TARGET / 2)
            begin
                drain_results();
                paused = 1'b1;
            end
        end

        drain_results();
        repeat (10) @(posedge clk);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
